// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/cst_pkg.sv =====
// ---------------------------------------------------------------------------
// Cursor sequence table package
// Sizes, operation and status codes, and controller/datapath interface types.
// ---------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int OP_W       = 3;
  localparam int STAT_W     = 2;

  localparam logic [OP_W-1:0] OP_START   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADVANCE = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd2;
  localparam logic [OP_W-1:0] OP_ATTACH  = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_ITEM = 2'd2;

  typedef struct packed {
    logic              load;
    logic              stat_we;
    logic [STAT_W-1:0] stat;
    logic              cur_zero;
    logic              cur_inc;
    logic              setup_up;
    logic              setup_dn;
    logic              shift;
    logic              fin_add;
    logic              fin_rem;
    logic              rd_cur;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            have;
    logic            full;
    logic            rem_zero;
    logic            out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/cst_ctrl.sv =====
// ---------------------------------------------------------------------------
// Cursor sequence table controller
// Sequences decode, entry shifting, update, cursor read and result load.
// ---------------------------------------------------------------------------
`default_nettype none

module cst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cst_pkg::sts_t sts_i,
  output cst_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_FIN    = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_LOAD   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.stat = cst_pkg::ST_DONE;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.stat_we = 1'b1;
        state_d       = S_READ;
        case (sts_i.op)
          cst_pkg::OP_START: begin
            cmd_o.cur_zero = 1'b1;
          end
          cst_pkg::OP_ADVANCE: begin
            if (sts_i.have) begin
              cmd_o.cur_inc = 1'b1;
            end else begin
              cmd_o.stat = cst_pkg::ST_NO_ITEM;
            end
          end
          cst_pkg::OP_INSERT, cst_pkg::OP_ATTACH: begin
            if (sts_i.full) begin
              cmd_o.stat = cst_pkg::ST_FULL;
            end else begin
              cmd_o.setup_up = 1'b1;
              state_d        = S_SHIFT;
            end
          end
          cst_pkg::OP_REMOVE: begin
            if (!sts_i.have) begin
              cmd_o.stat = cst_pkg::ST_NO_ITEM;
            end else begin
              cmd_o.setup_dn = 1'b1;
              state_d        = S_SHIFT;
            end
          end
          default: begin
            state_d = S_READ;
          end
        endcase
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.rem_zero) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.op == cst_pkg::OP_REMOVE) begin
          cmd_o.fin_rem = 1'b1;
        end else begin
          cmd_o.fin_add = 1'b1;
        end
        state_d = S_READ;
      end
      S_READ: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = S_LOAD;
      end
      S_LOAD: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cst_dp.sv =====
// ---------------------------------------------------------------------------
// Cursor sequence table datapath
// Entry memory, count, cursor, shift pointer and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module cst_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cst_pkg::cmd_t                      cmd_i,
  output cst_pkg::sts_t                      sts_o,
  input  logic [cst_pkg::OP_W-1:0]           opcode_i,
  input  logic [cst_pkg::VALUE_BITS-1:0]     value_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic [cst_pkg::STAT_W-1:0]         status_o,
  output logic                               has_current_o,
  output logic [cst_pkg::VALUE_BITS-1:0]     current_value_o,
  output logic [cst_pkg::CNT_W-1:0]          count_o
);

  logic [cst_pkg::VALUE_BITS-1:0] mem [cst_pkg::CAPACITY];

  logic [cst_pkg::OP_W-1:0]       op_q;
  logic [cst_pkg::VALUE_BITS-1:0] val_q;
  logic [cst_pkg::CNT_W-1:0]      count_q, cursor_q, src_q, rem_q, pos_q, pos_d;
  logic                           up_q;
  logic                           wpend_q, wpend_d;
  logic [cst_pkg::ADDR_W-1:0]     waddr_q, waddr_d;
  logic [cst_pkg::VALUE_BITS-1:0] rd_q;
  logic [cst_pkg::STAT_W-1:0]     stat_q;
  logic                           out_valid_q;
  logic                           have, step, re, we;
  logic [cst_pkg::ADDR_W-1:0]     raddr, maddr;
  logic [cst_pkg::VALUE_BITS-1:0] wdata;

  assign have = cursor_q < count_q;
  assign step = cmd_i.shift && (rem_q != '0);

  always_comb begin
    if (op_q == cst_pkg::OP_INSERT) begin
      pos_d = have ? cursor_q : '0;
    end else begin
      pos_d = have ? cursor_q + cst_pkg::CNT_W'(1) : count_q;
    end
  end

  always_comb begin
    wpend_d = step;
    if (up_q) begin
      waddr_d = cst_pkg::ADDR_W'(src_q + cst_pkg::CNT_W'(1));
    end else begin
      waddr_d = cst_pkg::ADDR_W'(src_q - cst_pkg::CNT_W'(1));
    end
  end

  assign re    = step || cmd_i.rd_cur;
  assign raddr = cmd_i.shift ? src_q[cst_pkg::ADDR_W-1:0] : cursor_q[cst_pkg::ADDR_W-1:0];
  assign we    = wpend_q || cmd_i.fin_add;
  assign maddr = wpend_q ? waddr_q : pos_q[cst_pkg::ADDR_W-1:0];
  assign wdata = wpend_q ? rd_q : val_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[maddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      val_q <= value_i;
    end
    if (cmd_i.stat_we) begin
      stat_q <= cmd_i.stat;
    end
    if (cmd_i.setup_up) begin
      pos_q <= pos_d;
      rem_q <= count_q - pos_d;
      src_q <= count_q - cst_pkg::CNT_W'(1);
      up_q  <= 1'b1;
    end else if (cmd_i.setup_dn) begin
      pos_q <= cursor_q;
      rem_q <= count_q - cursor_q - cst_pkg::CNT_W'(1);
      src_q <= cursor_q + cst_pkg::CNT_W'(1);
      up_q  <= 1'b0;
    end else if (step) begin
      rem_q <= rem_q - cst_pkg::CNT_W'(1);
      src_q <= up_q ? src_q - cst_pkg::CNT_W'(1) : src_q + cst_pkg::CNT_W'(1);
    end
    if (step) begin
      waddr_q <= waddr_d;
    end
    if (cmd_i.out_load) begin
      status_o        <= stat_q;
      has_current_o   <= have;
      current_value_o <= have ? rd_q : '0;
      count_o         <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cursor_q    <= '0;
      wpend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wpend_q <= wpend_d;
      if (cmd_i.cur_zero) begin
        cursor_q <= '0;
      end else if (cmd_i.cur_inc) begin
        cursor_q <= cursor_q + cst_pkg::CNT_W'(1);
      end else if (cmd_i.fin_add) begin
        cursor_q <= pos_q;
      end
      if (cmd_i.fin_add) begin
        count_q <= count_q + cst_pkg::CNT_W'(1);
      end else if (cmd_i.fin_rem) begin
        count_q <= count_q - cst_pkg::CNT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.op       = op_q;
  assign sts_o.have     = have;
  assign sts_o.full     = count_q == cst_pkg::CNT_W'(cst_pkg::CAPACITY);
  assign sts_o.rem_zero = rem_q == '0;
  assign sts_o.out_busy = out_valid_q && out_stall_i;

endmodule

`default_nettype wire

// ===== rtl/cursor_sequence_table_unit.sv =====
// ---------------------------------------------------------------------------
// Cursor sequence table unit
// Ordered store of values with a cursor, driven by one opcode per transfer.
// ---------------------------------------------------------------------------
// One item is handled at a time. Insert, attach and remove shift the entries
// past the point of change, and the entry memory moves one entry per cycle by
// reading one entry while writing the one read in the cycle before. The result
// sits in an output register, so the next item is taken while it waits.
`default_nettype none

module cursor_sequence_table_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [cst_pkg::OP_W-1:0]       opcode_i,
  input  logic [cst_pkg::VALUE_BITS-1:0] value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cst_pkg::STAT_W-1:0]     status_o,
  output logic                           has_current_o,
  output logic [cst_pkg::VALUE_BITS-1:0] current_value_o,
  output logic [cst_pkg::CNT_W-1:0]      count_o
);

  `include "assert_macros.svh"

  cst_pkg::cmd_t cmd;
  cst_pkg::sts_t sts;

  cst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cst_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .opcode_i        (opcode_i),
    .value_i         (value_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .has_current_o   (has_current_o),
    .current_value_o (current_value_o),
    .count_o         (count_o)
  );

  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o,
               "Input taken again straight after a transfer.")
  `ASSERT_IMPLIES(a_full_count, clk_i, rst_ni,
                  out_valid_o && (status_o == cst_pkg::ST_FULL),
                  count_o == cst_pkg::CNT_W'(cst_pkg::CAPACITY),
                  "Full status with spare capacity.")
  `ASSERT_IMPLIES(a_no_item_zero, clk_i, rst_ni, out_valid_o && !has_current_o,
                  current_value_o == '0, "Value reported with no current item.")
  `ASSERT_IMPLIES(a_add_not_full, clk_i, rst_ni, cmd.fin_add, !sts.full,
                  "Entry added to a full store.")

endmodule

`default_nettype wire

// ===== verif/cursor_sequence_table_checker.sv =====
// ---------------------------------------------------------------------------
// Cursor sequence table checker
// Watches the input and result channels of the cursor sequence table unit,
// keeps its own copy of the stored sequence and the cursor, predicts one
// result for every accepted input transfer and compares every result transfer
// field by field with the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module cursor_sequence_table_checker
  import cst_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [OP_W-1:0]       opcode_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [STAT_W-1:0]     status_i,
  input  logic                  has_current_i,
  input  logic [VALUE_BITS-1:0] current_value_i,
  input  logic [CNT_W-1:0]      count_i,
  output int                    error_count_o,
  output int                    outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [STAT_W-1:0]     status;
    logic                  has_current;
    logic [VALUE_BITS-1:0] current_value;
    logic [CNT_W-1:0]      count;
  } outcome_t;

  logic [VALUE_BITS-1:0] seq_store [CAPACITY];
  int                    seq_len    = 0;
  int                    cursor_pos = 0;
  int                    mismatches = 0;
  outcome_t              pending_outcomes [$];

  task automatic predict_outcome(input logic [OP_W-1:0] op, input logic [VALUE_BITS-1:0] val,
                                 output outcome_t res);
    int                idx;
    logic [STAT_W-1:0] st;
    st = ST_DONE;
    case (op)
      OP_START: begin
        cursor_pos = 0;
      end
      OP_ADVANCE: begin
        if (cursor_pos < seq_len) cursor_pos++;
        else st = ST_NO_ITEM;
      end
      OP_INSERT: begin
        if (seq_len >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          if (cursor_pos >= seq_len) cursor_pos = 0;
          for (idx = seq_len; idx > cursor_pos; idx--) seq_store[idx] = seq_store[idx-1];
          seq_store[cursor_pos] = val;
          seq_len++;
        end
      end
      OP_ATTACH: begin
        if (seq_len >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          if (cursor_pos < seq_len) begin
            cursor_pos++;
            for (idx = seq_len; idx > cursor_pos; idx--) seq_store[idx] = seq_store[idx-1];
          end else begin
            cursor_pos = seq_len;
          end
          seq_store[cursor_pos] = val;
          seq_len++;
        end
      end
      OP_REMOVE: begin
        if (cursor_pos >= seq_len) begin
          st = ST_NO_ITEM;
        end else begin
          for (idx = cursor_pos; idx + 1 < seq_len; idx++) seq_store[idx] = seq_store[idx+1];
          seq_len--;
        end
      end
      default: begin
      end
    endcase
    res.status        = st;
    res.has_current   = (cursor_pos < seq_len);
    res.current_value = res.has_current ? seq_store[cursor_pos] : '0;
    res.count         = CNT_W'(seq_len);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_transfers
    outcome_t predicted;
    outcome_t observed;
    if (!rst_ni) begin
      seq_len    = 0;
      cursor_pos = 0;
      pending_outcomes.delete();
      error_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predict_outcome(opcode_i, value_i, predicted);
        pending_outcomes.push_back(predicted);
      end
      if (out_valid_i && !out_stall_i) begin
        observed = '{status_i, has_current_i, current_value_i, count_i};
        if (pending_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result transfer with nothing expected: status %0d has_current %0b value %h count %0d",
                     $realtime, observed.status, observed.has_current,
                     observed.current_value, observed.count);
        end else begin
          predicted = pending_outcomes.pop_front();
          if (observed !== predicted) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: result mismatch: status %0d/%0d has_current %0b/%0b value %h/%h count %0d/%0d (expected/actual)",
                       $realtime, predicted.status, observed.status,
                       predicted.has_current, observed.has_current,
                       predicted.current_value, observed.current_value,
                       predicted.count, observed.count);
          end
        end
      end
      error_count_o <= mismatches;
      outstanding_o <= pending_outcomes.size();
    end
  end

endmodule

// ===== verif/cursor_sequence_table_unit_test.sv =====
// ---------------------------------------------------------------------------
// Cursor sequence table unit test
// Drives opcodes and values into the unit in bursts, first a directed run over
// the empty, single and edge cases, then phases that grow, shrink and wander
// the sequence so that it fills to capacity and drains to empty. The result
// side stalls on its own pattern, including long hold-offs that back the unit
// up. A checker beside the unit predicts and compares every result.
// ---------------------------------------------------------------------------
module cursor_sequence_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cst_pkg::*;

  localparam int RANDOM_ITEMS    = 1550;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int SETTLE_CYCLES   = 100;

  localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_REMOVE + 1'b1;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = '1;

  typedef enum int {PHASE_GROW, PHASE_SHRINK, PHASE_WANDER, PHASE_NOISE} phase_t;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       opcode        = OP_START;
  logic [VALUE_BITS-1:0] value         = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic [STAT_W-1:0]     status;
  logic                  has_current;
  logic [VALUE_BITS-1:0] current_value;
  logic [CNT_W-1:0]      count;
  int                    errors;
  int                    outstanding;
  int                    burst_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cursor_sequence_table_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .opcode_i        (opcode),
    .value_i         (value),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .has_current_o   (has_current),
    .current_value_o (current_value),
    .count_o         (count)
  );

  cursor_sequence_table_checker checker_inst (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .opcode_i        (opcode),
    .value_i         (value),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .status_i        (status),
    .has_current_i   (has_current),
    .current_value_i (current_value),
    .count_i         (count),
    .error_count_o   (errors),
    .outstanding_o   (outstanding)
  );

  task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_BITS-1:0] val);
    int gap;
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= val;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 10);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input phase_t ph);
    int roll;
    roll = $urandom_range(0, 99);
    case (ph)
      PHASE_GROW: begin
        if (roll < 35)      return OP_INSERT;
        else if (roll < 70) return OP_ATTACH;
        else if (roll < 80) return OP_ADVANCE;
        else if (roll < 90) return OP_START;
        else                return OP_REMOVE;
      end
      PHASE_SHRINK: begin
        if (roll < 50)      return OP_REMOVE;
        else if (roll < 70) return OP_START;
        else if (roll < 85) return OP_ADVANCE;
        else if (roll < 93) return OP_INSERT;
        else                return OP_ATTACH;
      end
      PHASE_WANDER: begin
        if (roll < 20)      return OP_START;
        else if (roll < 40) return OP_ADVANCE;
        else if (roll < 60) return OP_INSERT;
        else if (roll < 80) return OP_ATTACH;
        else                return OP_REMOVE;
      end
      default: begin
        if (roll < 40) return OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        else           return OP_W'($urandom_range(0, OP_SPARE_LAST));
      end
    endcase
  endfunction

  initial begin : receiver
    int stretch;
    int pct;
    int len;
    stretch = 0;
    @(posedge clk);
    forever begin
      if (stretch == 6 || stretch == 40) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        case ($urandom_range(0, 3))
          0:       pct = 0;
          1:       pct = 25;
          2:       pct = 60;
          default: pct = 90;
        endcase
        len = $urandom_range(10, 150);
        repeat (len) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
        end
      end
      stretch++;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("cursor_sequence_table_unit_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    phase_t          phase;
    int              phase_left;
    int              counted;
    int              roll;
    logic [OP_W-1:0] op;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    burst_left = $urandom_range(1, 40);

    // Empty sequence, then a handful of values walked through every case.
    send_item(OP_ADVANCE, '1);
    send_item(OP_REMOVE, '0);
    send_item(OP_START, 32'h1234_5678);
    send_item(OP_INSERT, '0);
    send_item(OP_ATTACH, '1);
    send_item(OP_ADVANCE, '0);
    send_item(OP_ATTACH, 32'hA5A5_A5A5);
    send_item(OP_ADVANCE, '1);
    send_item(OP_INSERT, 32'h5A5A_5A5A);
    send_item(OP_ADVANCE, '0);
    send_item(OP_INSERT, 32'h8000_0001);
    send_item(OP_START, '0);
    send_item(OP_REMOVE, '1);
    send_item(OP_ADVANCE, '0);
    send_item(OP_ADVANCE, '0);
    send_item(OP_REMOVE, '0);
    send_item(OP_REMOVE, '0);
    send_item(OP_REMOVE, '0);
    send_item(OP_SPARE_FIRST, '1);
    send_item(OP_SPARE_LAST, '1);
    send_item(OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), pick_value());
    send_item(OP_START, '0);

    counted    = 0;
    phase_left = 0;
    phase      = PHASE_GROW;
    while (counted < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 35)      phase = PHASE_GROW;
        else if (roll < 65) phase = PHASE_SHRINK;
        else if (roll < 90) phase = PHASE_WANDER;
        else                phase = PHASE_NOISE;
        phase_left = $urandom_range(40, 200);
      end
      op = pick_op(phase);
      send_item(op, pick_value());
      phase_left--;
      if (op <= OP_REMOVE) counted++;
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("cursor_sequence_table_unit_test: done, clean");
    end else begin
      $display("cursor_sequence_table_unit_test: done, errors");
    end
    $finish;
  end

endmodule
